[rtl/core/size_class_block_allocator_unit_macros.svh]
// Assertion helpers for the size-class block allocator.
// Each macro takes a label, an antecedent, a consequent and a message.
// Every check is clocked on clk and held off while rst_n is low.
`ifndef SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_MACROS_SVH
`define SIZE_CLASS_BLOCK_ALLOCATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCBA_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/scba_pkg.sv]
// ----------------------------------------------------------------------------
// scba_pkg
// Shared types and codes of the size-class block allocator.
// ----------------------------------------------------------------------------
package scba_pkg;

    // Widest pool id and block index that any parameter setting needs
    localparam int POOL_ID_W = 5;
    localparam int BLK_ID_W  = 10;

    // Operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_BAD_FREE  = 2'd3;

    // Classified command handed from the front end to the back end
    typedef struct packed {
        logic                 is_free;
        logic                 reject;
        logic [POOL_ID_W-1:0] pool;
        logic [BLK_ID_W-1:0]  index;
    } scba_cmd_t;

endpackage

[rtl/core/scba_front.sv]
// ----------------------------------------------------------------------------
// scba_front
// Accepts commands and classifies them: size class of an allocation, range
// check of a free.
// ----------------------------------------------------------------------------
module scba_front
    import scba_pkg::*;
#(
    parameter int MIN_SHIFT       = 5,
    parameter int POW2_CLASSES    = 8,
    parameter int NUM_POOLS       = 16,
    parameter int BLOCKS_PER_POOL = 64
)
(
    input  logic        start,
    input  logic        op,
    input  logic [19:0] req_size,
    input  logic [3:0]  free_pool,
    input  logic [5:0]  free_index,
    input  logic [7:0]  header_bytes,
    input  logic        hold,
    output logic        busy,
    output logic        push,
    output scba_cmd_t   cmd
);

    localparam int LIN_SHIFT = MIN_SHIFT + POW2_CLASSES;
    localparam logic [31:0] LIN_BYTES = 32'd1 << LIN_SHIFT;
    localparam logic [31:0] TOP_POW2  = 32'd1 << (LIN_SHIFT - 1);

    logic [20:0] size_up;
    logic [21:0] total;
    logic [31:0] total_ext;
    logic [31:0] class_id;
    logic        too_large;
    logic        free_bad;

    // Round the request up to a word and add the header
    assign size_up   = 21'(req_size) + 21'd3;
    assign total     = 22'({size_up[20:2], 2'b00}) + 22'(header_bytes);
    assign total_ext = 32'(total);

    // Pick the smallest power-of-two class, or a linear class above them
    always_comb
    begin
        class_id = 32'(POW2_CLASSES - 1);
        if (total_ext > TOP_POW2)
        begin
            class_id = 32'(POW2_CLASSES) - 32'd1
                     + ((total_ext + LIN_BYTES - 32'd1) >> LIN_SHIFT);
        end
        else
        begin
            for (int i = POW2_CLASSES - 1; i >= 0; i--)
            begin
                if ((32'd1 << (MIN_SHIFT + i)) >= total_ext)
                    class_id = 32'(i);
            end
        end
    end

    assign too_large = class_id >= 32'(NUM_POOLS);
    assign free_bad  = (32'(free_pool) >= 32'(NUM_POOLS))
                    || (32'(free_index) >= 32'(BLOCKS_PER_POOL));

    // Build the command for the queue
    always_comb
    begin
        cmd.is_free = (op == OP_FREE);
        if (op == OP_FREE)
        begin
            cmd.reject = free_bad;
            cmd.pool   = POOL_ID_W'(free_pool);
            cmd.index  = BLK_ID_W'(free_index);
        end
        else
        begin
            cmd.reject = too_large;
            cmd.pool   = class_id[POOL_ID_W-1:0];
            cmd.index  = '0;
        end
    end

    assign busy = hold;
    assign push = start && !hold;

endmodule

[rtl/core/scba_queue.sv]
// ----------------------------------------------------------------------------
// scba_queue
// Two-entry command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module scba_queue
    import scba_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  scba_cmd_t push_cmd,
    input  logic      pop,
    output scba_cmd_t pop_cmd,
    output logic      empty,
    output logic      full
);

    scba_cmd_t   entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [1:0]  count_next;

    assign empty   = (count_reg == 2'd0);
    assign full    = (count_reg == 2'd2);
    assign pop_cmd = entry_reg[rd_ptr_reg];

    // Track occupancy
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
        end
    end

    // Hold entries
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

[rtl/core/scba_back.sv]
// ----------------------------------------------------------------------------
// scba_back
// Carries out allocations and frees on the per-pool free lists and the busy
// map, and drives the result.
// ----------------------------------------------------------------------------
`include "size_class_block_allocator_unit_macros.svh"

module scba_back
    import scba_pkg::*;
#(
    parameter int MIN_SHIFT       = 5,
    parameter int POW2_CLASSES    = 8,
    parameter int NUM_POOLS       = 16,
    parameter int BLOCKS_PER_POOL = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  scba_cmd_t   cmd,
    input  logic        cmd_ready,
    output logic        pop,
    output logic        clearing,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [3:0]  pool,
    output logic [5:0]  block_index,
    output logic [16:0] block_bytes,
    output logic [6:0]  used_in_pool
);

    localparam int IW    = (BLOCKS_PER_POOL > 1) ? $clog2(BLOCKS_PER_POOL) : 1;
    localparam int CW    = $clog2(BLOCKS_PER_POOL + 1);
    localparam int PW    = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
    localparam int DEPTH = NUM_POOLS * BLOCKS_PER_POOL;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [1:0] {S_CLR, S_IDLE, S_RD, S_EX} state_t;

    state_t          state_reg;
    scba_cmd_t       cur_reg;
    logic [AW-1:0]   clr_cnt_reg;
    logic [IW-1:0]   head_reg [NUM_POOLS];
    logic [IW-1:0]   tail_reg [NUM_POOLS];
    logic [CW-1:0]   used_reg [NUM_POOLS];
    logic [CW-1:0]   fill_reg [NUM_POOLS];
    logic [IW-1:0]   fq_rd_reg;
    logic            bm_rd_reg;

    logic            valid_reg;
    logic [1:0]      status_reg;
    logic [3:0]      pool_reg;
    logic [5:0]      index_reg;
    logic [16:0]     bytes_reg;
    logic [6:0]      used_out_reg;

    // Free-list and busy-map memories
    logic [IW-1:0]   fq_mem [DEPTH];
    logic            bm_mem [DEPTH];

    logic [PW-1:0]   pid;
    logic [AW-1:0]   base;
    logic [AW-1:0]   fq_rd_addr;
    logic [AW-1:0]   bm_rd_addr;
    logic [IW-1:0]   slot_idx;
    logic [CW-1:0]   used_cur;
    logic [31:0]     cls_bytes;
    logic            alloc_ok;
    logic            free_ok;
    logic            bm_we;
    logic [AW-1:0]   bm_wr_addr;
    logic            bm_wr_data;
    logic            fq_we;
    logic [AW-1:0]   fq_wr_addr;

    logic [1:0]      status_next;
    logic [3:0]      pool_next;
    logic [5:0]      index_next;
    logic [16:0]     bytes_next;
    logic [6:0]      used_next;

    assign pid        = cur_reg.pool[PW-1:0];
    assign base       = AW'(pid) * AW'(BLOCKS_PER_POOL);
    assign fq_rd_addr = base + AW'(head_reg[pid]);
    assign bm_rd_addr = base + AW'(cur_reg.index[IW-1:0]);
    assign used_cur   = used_reg[pid];

    // Slots never written stand for their own index, taken from the head pointer
    assign slot_idx = (fill_reg[pid] > CW'(head_reg[pid])) ? fq_rd_reg : head_reg[pid];

    // Capacity of the current class
    always_comb
    begin
        if (32'(pid) < 32'(POW2_CLASSES))
            cls_bytes = 32'd1 << (MIN_SHIFT + 32'(pid));
        else
            cls_bytes = (32'(pid) - 32'(POW2_CLASSES) + 32'd1)
                        << (MIN_SHIFT + POW2_CLASSES);
    end

    assign alloc_ok = (state_reg == S_EX) && !cur_reg.is_free && !cur_reg.reject
                   && (used_cur != CW'(BLOCKS_PER_POOL));
    assign free_ok  = (state_reg == S_EX) && cur_reg.is_free && !cur_reg.reject
                   && bm_rd_reg;

    // Memory write ports
    assign fq_we      = free_ok;
    assign fq_wr_addr = base + AW'(tail_reg[pid]);
    assign bm_we      = (state_reg == S_CLR) || alloc_ok || free_ok;
    assign bm_wr_addr = (state_reg == S_CLR) ? clr_cnt_reg
                      : (alloc_ok ? base + AW'(slot_idx) : bm_rd_addr);
    assign bm_wr_data = alloc_ok;

    // Build the result
    always_comb
    begin
        status_next = ST_OK;
        pool_next   = cur_reg.pool[3:0];
        index_next  = '0;
        bytes_next  = cls_bytes[16:0];
        used_next   = 7'(used_cur);
        if (!cur_reg.is_free)
        begin
            if (cur_reg.reject)
            begin
                status_next = ST_TOO_LARGE;
                pool_next   = '0;
                bytes_next  = '0;
                used_next   = '0;
            end
            else if (used_cur == CW'(BLOCKS_PER_POOL))
            begin
                status_next = ST_EMPTY;
            end
            else
            begin
                index_next = 6'(slot_idx);
                used_next  = 7'(used_cur + CW'(1));
            end
        end
        else
        begin
            index_next = cur_reg.index[5:0];
            if (cur_reg.reject)
            begin
                status_next = ST_BAD_FREE;
                bytes_next  = '0;
                used_next   = '0;
            end
            else if (!bm_rd_reg)
            begin
                status_next = ST_BAD_FREE;
            end
            else
            begin
                used_next = 7'(used_cur - CW'(1));
            end
        end
    end

    assign pop      = (state_reg == S_IDLE) && cmd_ready;
    assign clearing = (state_reg == S_CLR);

    // Sweep the busy map after reset, then sequence each command: take, read, execute
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLR;
            clr_cnt_reg <= '0;
            valid_reg   <= 1'b0;
            for (int p = 0; p < NUM_POOLS; p++)
            begin
                head_reg[p] <= '0;
                tail_reg[p] <= '0;
                used_reg[p] <= '0;
                fill_reg[p] <= '0;
            end
        end
        else
        begin
            valid_reg <= 1'b0;
            case (state_reg)
                S_CLR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(DEPTH - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (cmd_ready)
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_EX;
                end
                S_EX:
                begin
                    state_reg <= S_IDLE;
                    valid_reg <= 1'b1;
                    if (alloc_ok)
                    begin
                        head_reg[pid] <= (head_reg[pid] == IW'(BLOCKS_PER_POOL - 1))
                                         ? '0 : head_reg[pid] + IW'(1);
                        used_reg[pid] <= used_cur + CW'(1);
                    end
                    if (free_ok)
                    begin
                        tail_reg[pid] <= (tail_reg[pid] == IW'(BLOCKS_PER_POOL - 1))
                                         ? '0 : tail_reg[pid] + IW'(1);
                        used_reg[pid] <= used_cur - CW'(1);
                        if (fill_reg[pid] != CW'(BLOCKS_PER_POOL))
                            fill_reg[pid] <= fill_reg[pid] + CW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Take the command and register the result
    always_ff @(posedge clk)
    begin
        if (pop)
            cur_reg <= cmd;
        if (state_reg == S_EX)
        begin
            status_reg   <= status_next;
            pool_reg     <= pool_next;
            index_reg    <= index_next;
            bytes_reg    <= bytes_next;
            used_out_reg <= used_next;
        end
    end

    // Memory ports
    always_ff @(posedge clk)
    begin
        fq_rd_reg <= fq_mem[fq_rd_addr];
        bm_rd_reg <= bm_mem[bm_rd_addr];
        if (fq_we)
            fq_mem[fq_wr_addr] <= cur_reg.index[IW-1:0];
        if (bm_we)
            bm_mem[bm_wr_addr] <= bm_wr_data;
    end

    assign result_valid = valid_reg;
    assign status       = status_reg;
    assign pool         = pool_reg;
    assign block_index  = index_reg;
    assign block_bytes  = bytes_reg;
    assign used_in_pool = used_out_reg;

    `SCBA_ASSERT_NEXT(a_ex_gives_result, state_reg == S_EX, valid_reg, "execute without result")
    `SCBA_ASSERT_NEXT(a_result_only_after_ex, state_reg != S_EX, !valid_reg, "stray result")
    `SCBA_ASSERT_SAME(a_no_take_in_clear, state_reg == S_CLR, !pop, "command taken while clearing")
    `SCBA_ASSERT_SAME(a_used_bounded, state_reg == S_EX, used_cur <= CW'(BLOCKS_PER_POOL), "used count overflow")

endmodule

[rtl/core/size_class_block_allocator_unit.sv]
// ----------------------------------------------------------------------------
// size_class_block_allocator_unit
// Pool allocator with power-of-two and linear size classes, one FIFO free
// list per pool and a busy map of handed-out blocks.
// ----------------------------------------------------------------------------
// Channel   Handshake                      Payload
// command   start / busy                   op, req_size, free_pool, free_index
// result    result_valid (one cycle)       status, pool, block_index,
//                                          block_bytes, used_in_pool
// config    APB psel/penable/pwrite        paddr, pwdata, prdata
//
// Each command passes from acceptance to result through the queue, memory
// read, execute and result register; the back end takes a new command only
// once it has finished the last. After reset the busy map is swept with
// busy high. A two-entry queue lets the front end accept while the back end
// works; busy rises when it is full. The receiver cannot stall results.
// ----------------------------------------------------------------------------
module size_class_block_allocator_unit
    import scba_pkg::*;
#(
    parameter int MIN_SHIFT       = 5,
    parameter int POW2_CLASSES    = 8,
    parameter int NUM_POOLS       = 16,
    parameter int BLOCKS_PER_POOL = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        op,
    input  logic [19:0] req_size,
    input  logic [3:0]  free_pool,
    input  logic [5:0]  free_index,
    output logic        result_valid,
    output logic [1:0]  status,
    output logic [3:0]  pool,
    output logic [5:0]  block_index,
    output logic [16:0] block_bytes,
    output logic [6:0]  used_in_pool,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_HEADER = 3'd0;

    logic [7:0] header_reg;
    logic       q_push;
    logic       q_pop;
    logic       q_empty;
    logic       q_full;
    logic       clearing;
    scba_cmd_t  push_cmd;
    scba_cmd_t  pop_cmd;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            header_reg <= 8'd28;
        else if (psel && penable && pwrite && (paddr == ADDR_HEADER))
            header_reg <= pwdata[7:0];
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_HEADER) ? 32'(header_reg) : '0;

    scba_front #(
        .MIN_SHIFT       (MIN_SHIFT),
        .POW2_CLASSES    (POW2_CLASSES),
        .NUM_POOLS       (NUM_POOLS),
        .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
    ) u_front (
        .start        (start),
        .op           (op),
        .req_size     (req_size),
        .free_pool    (free_pool),
        .free_index   (free_index),
        .header_bytes (header_reg),
        .hold         (q_full || clearing),
        .busy         (busy),
        .push         (q_push),
        .cmd          (push_cmd)
    );

    scba_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    scba_back #(
        .MIN_SHIFT       (MIN_SHIFT),
        .POW2_CLASSES    (POW2_CLASSES),
        .NUM_POOLS       (NUM_POOLS),
        .BLOCKS_PER_POOL (BLOCKS_PER_POOL)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (pop_cmd),
        .cmd_ready    (!q_empty),
        .pop          (q_pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .status       (status),
        .pool         (pool),
        .block_index  (block_index),
        .block_bytes  (block_bytes),
        .used_in_pool (used_in_pool)
    );

endmodule

[tb/sv/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the size-class block allocator. A scoreboard keeps
// its own free lists, busy map and header size, predicts one result per
// accepted command and compares every result strobe field by field. Stimulus
// mixes directed corner cases with random alloc/free traffic under several
// header sizes.
// ----------------------------------------------------------------------------
import scba_pkg::*;

typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  pool;
    logic [5:0]  block_index;
    logic [16:0] block_bytes;
    logic [6:0]  used_in_pool;
} alloc_result_t;

class alloc_scoreboard;
    logic [5:0]    free_list [16][64];
    logic [5:0]    head [16];
    logic [5:0]    tail [16];
    int            avail [16];
    bit            in_use [16][64];
    logic [7:0]    header;
    alloc_result_t pending [$];
    int            mismatches;
    int            checked;
    int            n_ok, n_large, n_empty, n_bad;

    function new();
        header = 8'd28;
        mismatches = 0;
        checked = 0;
        for (int p = 0; p < 16; p++)
        begin
            head[p] = 0;
            tail[p] = 0;
            avail[p] = 64;
            for (int i = 0; i < 64; i++)
            begin
                free_list[p][i] = i[5:0];
                in_use[p][i] = 0;
            end
        end
    endfunction

    function longint unsigned pool_capacity(int p);
        if (p < 8)
            return 64'd32 << p;
        return 64'd8192 * (p - 7);
    endfunction

    function int size_class(longint unsigned total);
        int p;
        p = 0;
        if (total > pool_capacity(7))
            return 8 + int'((total + 8191) / 8192) - 1;
        while (p < 7 && pool_capacity(p) < total)
            p++;
        return p;
    endfunction

    // Predict the result of one accepted command and update the pool state
    function void note_command(logic cmd_op, logic [19:0] size, logic [3:0] fp,
                               logic [5:0] fi);
        alloc_result_t r;
        longint unsigned total;
        int p;
        int idx;
        r = '0;
        if (cmd_op == OP_ALLOC)
        begin
            total = ((longint'(size) + 3) & ~64'd3) + header;
            p = size_class(total);
            if (p >= 16)
                r.status = ST_TOO_LARGE;
            else if (avail[p] == 0)
            begin
                r.status = ST_EMPTY;
                r.pool = p[3:0];
                r.block_bytes = 17'(pool_capacity(p));
                r.used_in_pool = 7'd64;
            end
            else
            begin
                idx = free_list[p][head[p]];
                head[p] = head[p] + 6'd1;
                avail[p]--;
                in_use[p][idx] = 1;
                r.status = ST_OK;
                r.pool = p[3:0];
                r.block_index = idx[5:0];
                r.block_bytes = 17'(pool_capacity(p));
                r.used_in_pool = 7'(64 - avail[p]);
            end
        end
        else
        begin
            r.pool = fp;
            r.block_index = fi;
            r.block_bytes = 17'(pool_capacity(fp));
            if (!in_use[fp][fi])
            begin
                r.status = ST_BAD_FREE;
            end
            else
            begin
                in_use[fp][fi] = 0;
                free_list[fp][tail[fp]] = fi;
                tail[fp] = tail[fp] + 6'd1;
                avail[fp]++;
                r.status = ST_OK;
            end
            r.used_in_pool = 7'(64 - avail[fp]);
        end
        case (r.status)
            ST_OK:        n_ok++;
            ST_TOO_LARGE: n_large++;
            ST_EMPTY:     n_empty++;
            default:      n_bad++;
        endcase
        pending.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
        alloc_result_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result %p", got);
            return;
        end
        want = pending.pop_front();
        checked++;
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch at result %0d: expected %p, got %p",
                         checked, want, got);
        end
    endfunction
endclass

module tb_top;
    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        op;
    logic [19:0] req_size;
    logic [3:0]  free_pool;
    logic [5:0]  free_index;
    logic        result_valid;
    logic [1:0]  status;
    logic [3:0]  pool;
    logic [5:0]  block_index;
    logic [16:0] block_bytes;
    logic [6:0]  used_in_pool;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    localparam int REG_HEADER = 0;
    localparam int CYCLE_LIMIT = 400000;

    alloc_scoreboard sb;
    int              cycles = 0;
    int              burst_left;
    logic [3:0]      held_pool [$];
    logic [5:0]      held_index [$];

    size_class_block_allocator_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Check each result strobe; count cycles toward the limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && result_valid)
            sb.check_result({status, pool, block_index, block_bytes, used_in_pool});
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAIL size_class_block_allocator_unit");
            $finish;
        end
    end

    task automatic write_header(int value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 3'(4 * REG_HEADER);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.header = value[7:0];
    endtask

    // Drop start at the end of a burst that is cut short
    task automatic end_burst();
        if (burst_left != 0)
        begin
            start <= 1'b0;
            burst_left = 0;
        end
    endtask

    // Wait for every pending result, then let the pipeline drain
    task automatic drain();
        end_burst();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Present one command; hold it until the transfer is taken
    task automatic send(logic cmd_op, logic [19:0] size, logic [3:0] fp, logic [5:0] fi);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        start      <= 1'b1;
        op         <= cmd_op;
        req_size   <= size;
        free_pool  <= fp;
        free_index <= fi;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_command(cmd_op, size, fp, fi);
        if (cmd_op == OP_ALLOC && sb.pending[$].status == ST_OK)
        begin
            held_pool.push_back(sb.pending[$].pool);
            held_index.push_back(sb.pending[$].block_index);
        end
        burst_left--;
        if (burst_left == 0)
            start <= 1'b0;
    endtask

    task automatic free_random_held();
        int k;
        k = $urandom_range(0, held_pool.size() - 1);
        send(OP_FREE, 20'($urandom), held_pool[k], held_index[k]);
        held_pool.delete(k);
        held_index.delete(k);
    endtask

    task automatic random_traffic(int count);
        int kind;
        logic [19:0] sz;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 45)
            begin
                // mostly small sizes, a few reaching the linear classes and beyond
                case ($urandom_range(0, 9))
                    0:       sz = 20'($urandom);
                    1, 2:    sz = 20'($urandom_range(4000, 140000));
                    default: sz = 20'($urandom_range(0, 600));
                endcase
                send(OP_ALLOC, sz, 4'($urandom), 6'($urandom));
            end
            else if (kind < 85 && held_pool.size() != 0)
                free_random_held();
            else
                send(OP_FREE, 20'($urandom), 4'($urandom), 6'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        burst_left = 0;
        rst_n = 1'b0;
        start = 1'b0;
        op = OP_ALLOC;
        req_size = '0;
        free_pool = '0;
        free_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: class edges, extremes, bad frees, exhaustion of one pool
        send(OP_ALLOC, 20'd0, 4'd0, 6'd0);
        send(OP_ALLOC, 20'd1, 4'd15, 6'd63);
        send(OP_ALLOC, 20'd4, 4'd0, 6'd0);
        send(OP_ALLOC, 20'd5, 4'd0, 6'd0);
        send(OP_ALLOC, 20'd4068, 4'd0, 6'd0);
        send(OP_ALLOC, 20'd4069, 4'd0, 6'd0);
        send(OP_ALLOC, 20'd8164, 4'd0, 6'd0);
        send(OP_ALLOC, 20'd65508, 4'd0, 6'd0);
        send(OP_ALLOC, 20'd65509, 4'd0, 6'd0);
        send(OP_ALLOC, 20'hFFFFF, 4'd0, 6'd0);
        send(OP_FREE, 20'hFFFFF, 4'd15, 6'd63);
        send(OP_FREE, 20'd0, 4'd3, 6'd9);
        send(OP_FREE, 20'd0, 4'd0, 6'd0);
        send(OP_FREE, 20'd0, 4'd0, 6'd0);
        for (int i = 0; i < 66; i++)
            send(OP_ALLOC, 20'd300, 4'd0, 6'd0);
        drain();

        // Random traffic under several header sizes, pausing for a full drain
        write_header(0);
        random_traffic(150);
        drain();
        write_header(255);
        random_traffic(150);
        drain();
        write_header(4);
        random_traffic(150);
        drain();
        write_header(32'h0000_00AB);
        random_traffic(120);

        drain();
        repeat (20) @(posedge clk);
        $display("covered %0d results: %0d ok, %0d too large, %0d pool empty, %0d bad free",
                 sb.checked, sb.n_ok, sb.n_large, sb.n_empty, sb.n_bad);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASS size_class_block_allocator_unit");
        else
        begin
            $display("%0d mismatches, %0d results missing", sb.mismatches,
                     sb.pending.size());
            $display("FAIL size_class_block_allocator_unit");
        end
        $finish;
    end
endmodule

[files.f]
+incdir+rtl/core
rtl/core/scba_pkg.sv
rtl/core/scba_front.sv
rtl/core/scba_queue.sv
rtl/core/scba_back.sv
rtl/core/size_class_block_allocator_unit.sv
tb/sv/tb_top.sv
